[hw/rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clk edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sts_pkg.sv]
package sts_pkg;

  localparam int NOTE_COUNT_DEF = 128;

  localparam int NOTE_W    = 7;
  localparam int PITCH_W   = 16;
  localparam int TIME_W    = 32;
  localparam int COIL_W    = 4;
  localparam int IDX_W     = 2;

  localparam int US_PER_SECOND = 1000000;
  localparam int QUO_W         = $clog2(US_PER_SECOND + 1);
  localparam int REM_W         = PITCH_W + 1;
  localparam int CNT_W         = $clog2(QUO_W);

  localparam logic REQ_NOTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [1:0] {
    MODE_INIT = 2'd0,
    MODE_PLAY = 2'd1,
    MODE_IDLE = 2'd2
  } mode_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_stat_t;

  function automatic logic [COIL_W-1:0] coil_of(input logic [IDX_W-1:0] idx);
    logic [COIL_W-1:0] c;
    case (idx)
      2'd0:    c = 4'd5;
      2'd1:    c = 4'd6;
      2'd2:    c = 4'd10;
      2'd3:    c = 4'd9;
      default: c = 4'd5;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/sts_div.sv]
module sts_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sts_pkg::PITCH_W-1:0] divisor,
  output sts_pkg::div_stat_t          stat
);
  import sts_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [QUO_W-1:0]    quo_r, quo_nxt;
  logic [PITCH_W-1:0]  dvs_r, dvs_nxt;
  logic [REM_W-1:0]    sh;
  logic [REM_W:0]      diff;

  always_comb begin
    sh   = {rem_r[REM_W-2:0], quo_r[QUO_W-1]};
    diff = {1'b0, sh} - {2'b00, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = QUO_W'(US_PER_SECOND);
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (diff[REM_W]) begin
        rem_nxt = sh;
        quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
      end else begin
        rem_nxt = diff[REM_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(QUO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.done = done_r;
  assign stat.quo  = quo_r;

endmodule

[hw/rtl/stepper_tone_sequencer_core.sv]
// channel | direction | handshake         | payload
// in      | into core | in_valid/in_stall | in_req_type in_note in_pitch_hz in_now_us
// out     | from core | out_valid/out_stall | out_coils out_stepped out_note_taken
//
// A set-note beat and most ticks show their result the cycle after accept.
// A tick that starts a note with nonzero pitch runs the restoring divider, one quotient
// bit per cycle, 20 bits; the core waits in S_DIV for its done, then shows the result.
// One beat at a time; in_stall stays high until the result beat is taken.
// out_stall holds the result beat and the core; synchronous reset, rst_n low.
module stepper_tone_sequencer_core #(
  parameter int NOTE_COUNT = sts_pkg::NOTE_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_req_type,
  input  logic [sts_pkg::NOTE_W-1:0]  in_note,
  input  logic [sts_pkg::PITCH_W-1:0] in_pitch_hz,
  input  logic [sts_pkg::TIME_W-1:0]  in_now_us,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sts_pkg::COIL_W-1:0]  out_coils,
  output logic                        out_stepped,
  output logic                        out_note_taken
);
  import sts_pkg::*;

  typedef enum logic [1:0] {
    S_READY,
    S_DIV,
    S_OUT
  } st_t;

  st_t                 state_r, state_nxt;
  mode_t               mode_r, mode_nxt;
  logic [NOTE_W-1:0]   cur_note_r, cur_note_nxt;
  logic [PITCH_W-1:0]  cur_pitch_r, cur_pitch_nxt;
  logic                dir_fwd_r, dir_fwd_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [TIME_W-1:0]   last_time_r, last_time_nxt;
  logic [TIME_W-1:0]   period_r, period_nxt;
  logic [COIL_W-1:0]   coil_r, coil_nxt;
  logic                stepped_r, stepped_nxt;
  logic                taken_r, taken_nxt;
  logic                div_start;
  logic                note_ok;
  logic [TIME_W-1:0]   elapsed;
  div_stat_t           div_stat;

  sts_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (cur_pitch_r),
    .stat    (div_stat)
  );

  assign note_ok = ({1'b0, in_note} < 8'(NOTE_COUNT));
  assign elapsed = in_now_us - last_time_r;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    cur_note_nxt  = cur_note_r;
    cur_pitch_nxt = cur_pitch_r;
    dir_fwd_nxt   = dir_fwd_r;
    idx_nxt       = idx_r;
    last_time_nxt = last_time_r;
    period_nxt    = period_r;
    coil_nxt      = coil_r;
    stepped_nxt   = stepped_r;
    taken_nxt     = taken_r;
    div_start     = 1'b0;
    case (state_r)
      S_READY: begin
        if (in_valid) begin
          stepped_nxt = 1'b0;
          taken_nxt   = 1'b0;
          state_nxt   = S_OUT;
          if (in_req_type == REQ_NOTE) begin
            if (in_note != cur_note_r && note_ok) begin
              if (in_note != '0) begin
                dir_fwd_nxt = ~dir_fwd_r;
              end
              cur_note_nxt  = in_note;
              cur_pitch_nxt = in_pitch_hz;
              mode_nxt      = MODE_INIT;
              taken_nxt     = 1'b1;
            end
          end else begin
            case (mode_r)
              MODE_INIT: begin
                if (cur_note_r != '0) begin
                  last_time_nxt = in_now_us;
                  mode_nxt      = MODE_PLAY;
                  if (cur_pitch_r == '0) begin
                    period_nxt = '1;
                  end else begin
                    div_start = 1'b1;
                    state_nxt = S_DIV;
                  end
                end else begin
                  coil_nxt = '0;
                  mode_nxt = MODE_IDLE;
                end
              end
              MODE_PLAY: begin
                if (elapsed >= period_r) begin
                  last_time_nxt = in_now_us;
                  idx_nxt       = dir_fwd_r ? idx_r + 1'b1 : idx_r - 1'b1;
                  coil_nxt      = coil_of(idx_nxt);
                  stepped_nxt   = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          period_nxt = TIME_W'(div_stat.quo);
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_READY;
        end
      end
      default: state_nxt = S_READY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_READY;
      mode_r      <= MODE_INIT;
      cur_note_r  <= '0;
      cur_pitch_r <= '0;
      dir_fwd_r   <= 1'b0;
      idx_r       <= '0;
      last_time_r <= '0;
      period_r    <= '0;
      coil_r      <= '0;
      stepped_r   <= 1'b0;
      taken_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      cur_note_r  <= cur_note_nxt;
      cur_pitch_r <= cur_pitch_nxt;
      dir_fwd_r   <= dir_fwd_nxt;
      idx_r       <= idx_nxt;
      last_time_r <= last_time_nxt;
      period_r    <= period_nxt;
      coil_r      <= coil_nxt;
      stepped_r   <= stepped_nxt;
      taken_r     <= taken_nxt;
    end
  end

  assign in_stall       = (state_r != S_READY);
  assign out_valid      = (state_r == S_OUT);
  assign out_coils      = coil_r;
  assign out_stepped    = stepped_r;
  assign out_note_taken = taken_r;

endmodule

[hw/rtl/sts_checker.sv]
`include "assert_macros.svh"

module sts_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [sts_pkg::COIL_W-1:0]  out_coils,
  input logic                        out_stepped,
  input logic                        out_note_taken
);

  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_coils) && $stable(out_stepped) && $stable(out_note_taken), "result beat changed while stalled")
  `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken again before result beat")
  `ASSERT_IMPL(a_out_blocks_in, out_valid, in_stall, "input ready while result beat pending")
  `ASSERT_IMPL(a_flags_exclusive, out_valid, !(out_stepped && out_note_taken), "step and note flags both set")
  `ASSERT_IMPL(a_step_coils, out_valid && out_stepped, out_coils == 4'd5 || out_coils == 4'd6 || out_coils == 4'd10 || out_coils == 4'd9, "step gave illegal coil pattern")

endmodule

bind stepper_tone_sequencer_core sts_checker u_sts_checker (.*);

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import sts_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_BEATS = 550;
  localparam int QUIET_FROM   = 470;
  localparam int PAUSE_AT     = 320;
  localparam int HOLD_AFTER   = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int SHOW_FAULTS  = 30;

  localparam logic [COIL_W-1:0] COIL_STEPS [4] = '{4'd5, 4'd6, 4'd10, 4'd9};

  typedef struct packed {
    logic [COIL_W-1:0] coils;
    logic              stepped;
    logic              taken;
  } drive_t;

  typedef struct packed {
    logic               req;
    logic [NOTE_W-1:0]  note;
    logic [PITCH_W-1:0] pitch;
    logic [TIME_W-1:0]  now;
    logic               typed;
    drive_t             drive;
  } plan_row_t;

  localparam int PLAN_ROWS = 25;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{REQ_TICK, 7'd0,   16'd0,     32'd0,           1'b1, '{4'd0,  1'b0, 1'b0}},
    '{REQ_TICK, 7'd0,   16'd0,     32'hFFFF_FFFF,   1'b1, '{4'd0,  1'b0, 1'b0}},
    '{REQ_NOTE, 7'd0,   16'd0,     32'd0,           1'b1, '{4'd0,  1'b0, 1'b0}},
    '{REQ_NOTE, 7'd127, 16'hFFFF,  32'hFFFF_FFFF,   1'b1, '{4'd0,  1'b0, 1'b1}},
    '{REQ_NOTE, 7'd127, 16'd5,     32'd0,           1'b1, '{4'd0,  1'b0, 1'b0}},
    '{REQ_TICK, 7'd0,   16'd0,     32'd100,         1'b1, '{4'd0,  1'b0, 1'b0}},
    '{REQ_TICK, 7'd127, 16'hFFFF,  32'd114,         1'b1, '{4'd0,  1'b0, 1'b0}},
    '{REQ_TICK, 7'd0,   16'd0,     32'd115,         1'b1, '{4'd6,  1'b1, 1'b0}},
    '{REQ_TICK, 7'd0,   16'd0,     32'd130,         1'b1, '{4'd10, 1'b1, 1'b0}},
    '{REQ_TICK, 7'd0,   16'd0,     32'd145,         1'b1, '{4'd9,  1'b1, 1'b0}},
    '{REQ_TICK, 7'd0,   16'd0,     32'd160,         1'b1, '{4'd5,  1'b1, 1'b0}},
    '{REQ_NOTE, 7'd1,   16'd0,     32'd0,           1'b1, '{4'd5,  1'b0, 1'b1}},
    '{REQ_TICK, 7'd0,   16'd0,     32'hFFFF_FFF0,   1'b1, '{4'd5,  1'b0, 1'b0}},
    '{REQ_TICK, 7'd0,   16'd0,     32'hFFFF_FFEE,   1'b1, '{4'd5,  1'b0, 1'b0}},
    '{REQ_TICK, 7'd0,   16'd0,     32'hFFFF_FFEF,   1'b1, '{4'd9,  1'b1, 1'b0}},
    '{REQ_NOTE, 7'd0,   16'd1234,  32'd0,           1'b1, '{4'd9,  1'b0, 1'b1}},
    '{REQ_TICK, 7'd0,   16'd0,     32'd5,           1'b1, '{4'd0,  1'b0, 1'b0}},
    '{REQ_TICK, 7'd0,   16'd0,     32'd6,           1'b1, '{4'd0,  1'b0, 1'b0}},
    '{REQ_NOTE, 7'd64,  16'd1,     32'd0,           1'b1, '{4'd0,  1'b0, 1'b1}},
    '{REQ_TICK, 7'd0,   16'd0,     32'hFFFF_FF00,   1'b1, '{4'd0,  1'b0, 1'b0}},
    '{REQ_TICK, 7'd0,   16'd0,     32'd999743,      1'b1, '{4'd0,  1'b0, 1'b0}},
    '{REQ_TICK, 7'd0,   16'd0,     32'd999744,      1'b1, '{4'd5,  1'b1, 1'b0}},
    '{REQ_NOTE, 7'd65,  16'd20000, 32'd0,           1'b0, '{4'd0,  1'b0, 1'b0}},
    '{REQ_TICK, 7'd0,   16'd0,     32'h7FFF_FFFF,   1'b0, '{4'd0,  1'b0, 1'b0}},
    '{REQ_TICK, 7'd0,   16'd0,     32'h8000_0031,   1'b0, '{4'd0,  1'b0, 1'b0}}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_req_type = REQ_NOTE;
  logic [NOTE_W-1:0]  in_note = '0;
  logic [PITCH_W-1:0] in_pitch_hz = '0;
  logic [TIME_W-1:0]  in_now_us = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COIL_W-1:0]  out_coils;
  logic               out_stepped;
  logic               out_note_taken;

  always #2 clk = ~clk;

  stepper_tone_sequencer_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_note        (in_note),
    .in_pitch_hz    (in_pitch_hz),
    .in_now_us      (in_now_us),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_coils      (out_coils),
    .out_stepped    (out_stepped),
    .out_note_taken (out_note_taken)
  );

  mode_t              tone_mode;
  logic [NOTE_W-1:0]  note_now;
  logic [PITCH_W-1:0] pitch_now;
  logic               fwd;
  logic [IDX_W-1:0]   phase_idx;
  logic [TIME_W-1:0]  last_us;
  logic [TIME_W-1:0]  period_us;
  logic [COIL_W-1:0]  coil_drive;

  drive_t coil_expect [$];

  int  fault_count = 0;
  int  beats_sent = 0;
  int  results_seen = 0;
  int  notes_seen = 0;
  int  steps_seen = 0;
  int  cycle_count = 0;
  int  send_gap_odds = 4;
  int  recv_odds = 4;
  int  hold_left = 0;
  int  stall_left = 0;
  bit  held_off = 1'b0;
  bit  calm = 1'b0;

  function automatic drive_t advance_tone(input logic req, input logic [NOTE_W-1:0] note,
                                          input logic [PITCH_W-1:0] pitch,
                                          input logic [TIME_W-1:0] now);
    drive_t            d;
    logic [TIME_W-1:0] gone;
    d = '0;
    if (req == REQ_NOTE) begin
      if (note != note_now && int'(note) < NOTE_COUNT_DEF) begin
        if (note != '0) fwd = ~fwd;
        note_now  = note;
        pitch_now = pitch;
        tone_mode = MODE_INIT;
        d.taken   = 1'b1;
      end
    end else begin
      case (tone_mode)
        MODE_INIT: begin
          if (note_now != '0) begin
            period_us = (pitch_now == '0) ? '1 : 32'(US_PER_SECOND) / 32'(pitch_now);
            last_us   = now;
            tone_mode = MODE_PLAY;
          end else begin
            coil_drive = '0;
            tone_mode  = MODE_IDLE;
          end
        end
        MODE_PLAY: begin
          gone = now - last_us;
          if (gone >= period_us) begin
            last_us    = now;
            phase_idx  = fwd ? phase_idx + 2'd1 : phase_idx - 2'd1;
            coil_drive = COIL_STEPS[phase_idx];
            d.stepped  = 1'b1;
          end
        end
        default: ;
      endcase
    end
    d.coils = coil_drive;
    return d;
  endfunction

  task automatic send_beat(input logic req, input logic [NOTE_W-1:0] note,
                           input logic [PITCH_W-1:0] pitch, input logic [TIME_W-1:0] now,
                           input logic typed, input drive_t typed_drive);
    drive_t d;
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_note     <= note;
    in_pitch_hz <= pitch;
    in_now_us   <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    d = advance_tone(req, note, pitch, now);
    coil_expect.push_back(typed ? typed_drive : d);
    beats_sent++;
    if (!calm && send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    drive_t want;
    drive_t got;
    got = '{out_coils, out_stepped, out_note_taken};
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      notes_seen += got.taken;
      steps_seen += got.stepped;
      if (coil_expect.size() == 0) begin
        fault_count++;
        if (fault_count <= SHOW_FAULTS)
          $display("%0t: result beat with nothing expected, coils %h stepped %b taken %b",
                   $time, got.coils, got.stepped, got.taken);
      end else begin
        want = coil_expect.pop_front();
        if (want != got) begin
          fault_count++;
          if (fault_count <= SHOW_FAULTS) begin
            if (want.coils != got.coils)
              $display("%0t: coils expected %h actual %h", $time, want.coils, got.coils);
            if (want.stepped != got.stepped)
              $display("%0t: stepped expected %b actual %b", $time, want.stepped,
                       got.stepped);
            if (want.taken != got.taken)
              $display("%0t: note_taken expected %b actual %b", $time, want.taken,
                       got.taken);
          end
        end
      end
    end
    cycle_count++;
    if (cycle_count % 128 == 0) begin
      case ($urandom_range(0, 3))
        0:       recv_odds = 0;
        1:       recv_odds = 3;
        2:       recv_odds = 6;
        default: recv_odds = 12;
      endcase
    end
    if (!held_off && results_seen >= HOLD_AFTER) begin
      held_off  = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && recv_odds != 0 && $urandom_range(1, recv_odds) == 1) begin
      stall_left = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               coil_expect.size());
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    logic               paused;
    logic [NOTE_W-1:0]  nt;
    logic [PITCH_W-1:0] pt;
    logic [TIME_W-1:0]  clock_us;
    logic [TIME_W-1:0]  span;
    logic [TIME_W-1:0]  delta;
    int                 ticks;
    paused     = 1'b0;
    clock_us   = 32'hFFFF_F000;
    tone_mode  = MODE_INIT;
    note_now   = '0;
    pitch_now  = '0;
    fwd        = 1'b0;
    phase_idx  = '0;
    last_us    = '0;
    period_us  = '0;
    coil_drive = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < PLAN_ROWS; r++)
      send_beat(PLAN[r].req, PLAN[r].note, PLAN[r].pitch, PLAN[r].now, PLAN[r].typed,
                PLAN[r].drive);

    while (beats_sent < RANDOM_BEATS) begin
      calm = (beats_sent >= QUIET_FROM);
      case ($urandom_range(0, 3))
        0:       send_gap_odds = 0;
        1:       send_gap_odds = 3;
        2:       send_gap_odds = 6;
        default: send_gap_odds = 12;
      endcase
      if (!paused && beats_sent >= PAUSE_AT) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        while (coil_expect.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      if ($urandom_range(0, 9) == 0) clock_us = $urandom;
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4))
          send_beat(1'($urandom), 7'($urandom), 16'($urandom), $urandom, 1'b0, '0);
      end else begin
        case ($urandom_range(0, 9))
          0:       nt = '0;
          1:       nt = note_now;
          default: nt = 7'($urandom_range(1, 127));
        endcase
        case ($urandom_range(0, 7))
          0:       pt = '0;
          1:       pt = 16'($urandom);
          2:       pt = 16'($urandom_range(1, 50));
          default: pt = 16'($urandom_range(200, 20000));
        endcase
        span = (pt == '0) ? '1 : 32'(US_PER_SECOND) / 32'(pt);
        send_beat(REQ_NOTE, nt, pt, $urandom, 1'b0, '0);
        ticks = $urandom_range(2, 10);
        repeat (ticks) begin
          if (span <= 32'd200000)
            delta = $urandom_range(0, span + span / 2);
          else if ($urandom_range(0, 3) == 0)
            delta = span;
          else
            delta = $urandom_range(0, 400000);
          clock_us = clock_us + delta;
          send_beat(REQ_TICK, 7'($urandom), 16'($urandom), clock_us, 1'b0, '0);
        end
      end
    end

    in_valid <= 1'b0;
    while (coil_expect.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("run covered %0d beats (%0d directed): %0d notes taken, %0d coil steps",
             beats_sent, PLAN_ROWS, notes_seen, steps_seen);
    $display("%0d results checked, %0d mismatches", results_seen, fault_count);
    if (fault_count == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
